### hdl/traffic_light_mode_controller_assert.svh
// assertion macros for the traffic light mode controller
`ifndef TRAFFIC_LIGHT_MODE_CONTROLLER_ASSERT_SVH
`define TRAFFIC_LIGHT_MODE_CONTROLLER_ASSERT_SVH

// condition that holds at every clock outside reset
`define TLMC_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("tlmc: invariant violated");

// condition in one cycle implies a condition in the next
`define TLMC_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("tlmc: next-cycle check violated");

`endif

### hdl/tlmc_pkg.sv
// shared types and constants for the traffic light mode controller
`default_nettype none

package tlmc_pkg;

  localparam int TIME_BITS = 32;

  localparam int IN_BITS    = 16;
  localparam int OUT_BITS   = 32;
  localparam int ADDR_BITS  = 5;
  localparam int DATA_BITS  = 32;

  typedef logic [TIME_BITS-1:0] time_t;

  typedef enum logic [2:0] {
    PH_RED     = 3'd0,
    PH_YELLOW1 = 3'd1,
    PH_GREEN   = 3'd2,
    PH_FLICKER = 3'd3,
    PH_YELLOW2 = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    PAT_OFF    = 3'd0,
    PAT_RED    = 3'd1,
    PAT_YELLOW = 3'd2,
    PAT_GREEN  = 3'd3,
    PAT_ALL    = 3'd4
  } pattern_t;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_HOLD   = 2'd1,
    MODE_BLINK  = 2'd2,
    MODE_OFF    = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_RESTART = 3'd1,
    CMD_HOLD    = 3'd2,
    CMD_BLINK   = 3'd3,
    CMD_OFF     = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    REG_RED_TIME     = 3'd0,
    REG_YELLOW_TIME  = 3'd1,
    REG_GREEN_TIME   = 3'd2,
    REG_FLICKER_TIME = 3'd3,
    REG_FLICKER_TGL  = 3'd4,
    REG_DEBOUNCE     = 3'd5,
    REG_BLINK_TIME   = 3'd6
  } reg_idx_t;

  localparam logic [15:0] RED_TIME_RST     = 16'd2000;
  localparam logic [15:0] YELLOW_TIME_RST  = 16'd500;
  localparam logic [15:0] GREEN_TIME_RST   = 16'd2000;
  localparam logic [15:0] FLICKER_TIME_RST = 16'(1000 / 7);
  localparam logic [3:0]  FLICKER_TGL_RST  = 4'd7;
  localparam logic [7:0]  DEBOUNCE_RST     = 8'd50;
  localparam logic [15:0] BLINK_TIME_RST   = 16'd500;

  localparam logic [9:0] POT_FULL = 10'd1023;

endpackage

`default_nettype wire

### hdl/traffic_light_mode_controller.sv
// traffic light mode controller top level
`default_nettype none

// One input word is one millisecond tick carrying three raw active-low button
// levels, a pot sample and a mode command; each tick yields one output word
// with the three lamp PWM levels, the active mode and the cycle phase. A word
// is first captured in an input register, then one pass of logic updates the
// timer, debounce, mode and phase state, loads the output register when the
// output side is free, and accepts a new word every clock unless the output
// side stalls. The user must write configuration registers over the APB port
// only while no tick is in flight (not enforced); there is no start-up pass.
module traffic_light_mode_controller
  import tlmc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // button_one, button_two, button_three, pot_level[9:0], mode_command[2:0]
  input  wire logic [IN_BITS-1:0]   in_tdata,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  // red_level[7:0], yellow_level[7:0], green_level[7:0], active_mode[1:0],
  // cycle_phase[2:0], zero padding
  output logic [OUT_BITS-1:0]       out_tdata,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  input  wire logic                 cfg_psel,
  input  wire logic                 cfg_penable,
  input  wire logic                 cfg_pwrite,
  input  wire logic [ADDR_BITS-1:0] cfg_paddr,
  input  wire logic [DATA_BITS-1:0] cfg_pwdata,
  output logic [DATA_BITS-1:0]      cfg_prdata,
  output logic                      cfg_pready
);

  // configuration
  logic [15:0] red_time_r, yellow_time_r, green_time_r, flicker_time_r, blink_time_r;
  logic [3:0]  flicker_tgl_r;
  logic [7:0]  debounce_r;
  reg_idx_t    cfg_idx;
  logic        cfg_wr;

  // pipeline
  logic               in_valid_r;
  logic [IN_BITS-1:0] in_data_r;
  logic               out_valid_r;
  logic [7:0]         red_lvl_r, yel_lvl_r, grn_lvl_r;
  mode_t              out_mode_r;
  phase_t             out_phase_r;
  logic               advance;

  // block state
  time_t    time_r, phase_start_r, blink_start_r;
  phase_t   phase_r;
  logic [3:0] flick_cnt_r;
  pattern_t pat_r;
  mode_t    mode_r;
  logic [2:0] btn_level_r;
  time_t    btn_acc_r [3];

  time_t    phase_start_nxt, blink_start_nxt;
  phase_t   phase_nxt;
  logic [3:0] flick_cnt_nxt;
  pattern_t pat_nxt;
  mode_t    mode_nxt;
  logic [2:0] btn_level_nxt;
  time_t    btn_acc_nxt [3];
  logic [7:0] red_lvl_nxt, yel_lvl_nxt, grn_lvl_nxt;

  // unpacked input word
  logic [2:0] btn_in;
  logic [9:0] pot;
  cmd_t       cmd;

  // brightness = pot*255/1023
  logic [17:0] bright_x;
  logic [7:0]  bright_q0;
  logic [10:0] bright_rem;
  logic [7:0]  bright;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[ADDR_BITS-1:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    cfg_prdata = '0;
    unique case (cfg_idx)
      REG_RED_TIME:     cfg_prdata = {16'd0, red_time_r};
      REG_YELLOW_TIME:  cfg_prdata = {16'd0, yellow_time_r};
      REG_GREEN_TIME:   cfg_prdata = {16'd0, green_time_r};
      REG_FLICKER_TIME: cfg_prdata = {16'd0, flicker_time_r};
      REG_FLICKER_TGL:  cfg_prdata = {28'd0, flicker_tgl_r};
      REG_DEBOUNCE:     cfg_prdata = {24'd0, debounce_r};
      REG_BLINK_TIME:   cfg_prdata = {16'd0, blink_time_r};
      default:          cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_time_r     <= RED_TIME_RST;
      yellow_time_r  <= YELLOW_TIME_RST;
      green_time_r   <= GREEN_TIME_RST;
      flicker_time_r <= FLICKER_TIME_RST;
      flicker_tgl_r  <= FLICKER_TGL_RST;
      debounce_r     <= DEBOUNCE_RST;
      blink_time_r   <= BLINK_TIME_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_RED_TIME:     red_time_r     <= cfg_pwdata[15:0];
        REG_YELLOW_TIME:  yellow_time_r  <= cfg_pwdata[15:0];
        REG_GREEN_TIME:   green_time_r   <= cfg_pwdata[15:0];
        REG_FLICKER_TIME: flicker_time_r <= cfg_pwdata[15:0];
        REG_FLICKER_TGL:  flicker_tgl_r  <= cfg_pwdata[3:0];
        REG_DEBOUNCE:     debounce_r     <= cfg_pwdata[7:0];
        REG_BLINK_TIME:   blink_time_r   <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  assign btn_in = in_data_r[2:0];
  assign pot    = in_data_r[12:3];
  assign cmd    = cmd_t'(in_data_r[15:13]);

  assign bright_x   = {pot, 8'd0} - {8'd0, pot};
  assign bright_q0  = bright_x[17:10];
  assign bright_rem = {1'b0, bright_x[9:0]} + {3'd0, bright_q0};
  assign bright     = bright_q0 + {7'd0, (bright_rem >= {1'b0, POT_FULL})};

  always_comb begin
    time_t    now;
    time_t    elapsed;
    mode_t    bmode;
    logic [3:0] fc;

    now             = time_r;
    fc              = '0;
    phase_start_nxt = phase_start_r;
    blink_start_nxt = blink_start_r;
    phase_nxt       = phase_r;
    flick_cnt_nxt   = flick_cnt_r;
    pat_nxt         = pat_r;
    mode_nxt        = mode_r;
    btn_level_nxt   = btn_level_r;
    btn_acc_nxt     = btn_acc_r;
    red_lvl_nxt     = '0;
    yel_lvl_nxt     = '0;
    grn_lvl_nxt     = '0;

    for (int k = 0; k < 3; k++) begin
      bmode = mode_t'(2'(k + 1));
      if (btn_in[k] != btn_level_nxt[k] &&
          (now - btn_acc_nxt[k]) >= TIME_BITS'(debounce_r)) begin
        btn_acc_nxt[k] = now;
        if (btn_level_nxt[k] && !btn_in[k]) begin
          if (mode_nxt != bmode) begin
            mode_nxt = bmode;
            if (bmode == MODE_HOLD) pat_nxt = PAT_RED;
            else if (bmode == MODE_BLINK) pat_nxt = PAT_ALL;
            else pat_nxt = PAT_OFF;
          end else begin
            mode_nxt        = MODE_NORMAL;
            phase_start_nxt = now;
            phase_nxt       = PH_RED;
          end
        end
        btn_level_nxt[k] = btn_in[k];
      end
    end

    case (cmd)
      CMD_RESTART: begin
        mode_nxt        = MODE_NORMAL;
        phase_start_nxt = now;
        phase_nxt       = PH_RED;
      end
      CMD_HOLD: begin
        mode_nxt = MODE_HOLD;
        pat_nxt  = PAT_RED;
      end
      CMD_BLINK: begin
        mode_nxt = MODE_BLINK;
        pat_nxt  = PAT_ALL;
      end
      CMD_OFF: begin
        mode_nxt = MODE_OFF;
        pat_nxt  = PAT_OFF;
      end
      default: ;
    endcase

    elapsed = now - phase_start_nxt;
    if (mode_nxt == MODE_NORMAL) begin
      unique case (phase_nxt)
        PH_RED: begin
          pat_nxt = PAT_RED;
          if (elapsed >= TIME_BITS'(red_time_r)) begin
            phase_start_nxt = now;
            phase_nxt       = PH_YELLOW1;
          end
        end
        PH_YELLOW1: begin
          pat_nxt = PAT_YELLOW;
          if (elapsed >= TIME_BITS'(yellow_time_r)) begin
            phase_start_nxt = now;
            phase_nxt       = PH_GREEN;
          end
        end
        PH_GREEN: begin
          pat_nxt = PAT_GREEN;
          if (elapsed >= TIME_BITS'(green_time_r)) begin
            phase_start_nxt = now;
            phase_nxt       = PH_FLICKER;
            flick_cnt_nxt   = '0;
          end
        end
        PH_FLICKER: begin
          if (elapsed >= TIME_BITS'(flicker_time_r)) begin
            phase_start_nxt = now;
            pat_nxt         = (pat_nxt == PAT_GREEN) ? PAT_OFF : PAT_GREEN;
            fc              = flick_cnt_nxt + 4'd1;
            flick_cnt_nxt   = fc;
            if (fc >= flicker_tgl_r) phase_nxt = PH_YELLOW2;
          end
        end
        PH_YELLOW2: begin
          pat_nxt = PAT_YELLOW;
          if (elapsed >= TIME_BITS'(yellow_time_r)) begin
            phase_start_nxt = now;
            phase_nxt       = PH_RED;
          end
        end
        default: begin
          phase_start_nxt = now;
          phase_nxt       = PH_RED;
        end
      endcase
    end

    if (mode_nxt == MODE_BLINK) begin
      if ((now - blink_start_nxt) >= TIME_BITS'(blink_time_r)) begin
        blink_start_nxt = now;
        pat_nxt         = (pat_nxt == PAT_ALL) ? PAT_OFF : PAT_ALL;
      end
      if (pat_nxt == PAT_ALL) begin
        red_lvl_nxt = bright;
        yel_lvl_nxt = bright;
        grn_lvl_nxt = bright;
      end
    end else begin
      case (pat_nxt)
        PAT_RED:    red_lvl_nxt = bright;
        PAT_YELLOW: yel_lvl_nxt = bright;
        PAT_GREEN:  grn_lvl_nxt = bright;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      time_r        <= '0;
      phase_start_r <= '0;
      blink_start_r <= '0;
      phase_r       <= PH_RED;
      flick_cnt_r   <= '0;
      pat_r         <= PAT_OFF;
      mode_r        <= MODE_NORMAL;
      btn_level_r   <= '1;
      btn_acc_r     <= '{default: '0};
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r   <= 1'b1;
        time_r        <= time_r + 1'b1;
        phase_start_r <= phase_start_nxt;
        blink_start_r <= blink_start_nxt;
        phase_r       <= phase_nxt;
        flick_cnt_r   <= flick_cnt_nxt;
        pat_r         <= pat_nxt;
        mode_r        <= mode_nxt;
        btn_level_r   <= btn_level_nxt;
        btn_acc_r     <= btn_acc_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_data_r <= in_tdata;
    end
    if (advance) begin
      red_lvl_r   <= red_lvl_nxt;
      yel_lvl_r   <= yel_lvl_nxt;
      grn_lvl_r   <= grn_lvl_nxt;
      out_mode_r  <= mode_nxt;
      out_phase_r <= phase_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'd0, out_phase_r, out_mode_r, grn_lvl_r, yel_lvl_r, red_lvl_r};

`include "traffic_light_mode_controller_assert.svh"

  `TLMC_ASSERT_NEXT(a_time_steps, advance, time_r == TIME_BITS'($past(time_r) + 1'b1))
  `TLMC_ASSERT_NEXT(a_time_holds, !advance, $stable(time_r) && $stable(mode_r))
  `TLMC_ASSERT_NEXT(a_result_loaded, advance, out_valid_r && out_mode_r == mode_r)
  `TLMC_ASSERT_ALWAYS(a_hold_red, mode_r != MODE_HOLD || pat_r == PAT_RED)
  `TLMC_ASSERT_ALWAYS(a_off_dark, mode_r != MODE_OFF || pat_r == PAT_OFF)

endmodule

`default_nettype wire

### sim/tb.sv
// traffic light mode controller testbench: random and directed ticks, checked by predictor or table
`timescale 1ns / 1ps

module tb
  import tlmc_pkg::*;
();

  localparam logic [2:0] CMD_SPARE_5 = 3'd5;
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;
  localparam logic [2:0] BTN_UP = 3'b111;
  localparam int PHASE_ITEMS = 155;
  localparam int HOLD_AT = 21 + 5 * PHASE_ITEMS + 40;

  // btn[0] is button one
  typedef struct packed {
    logic [2:0] cmd;
    logic [9:0] pot;
    logic [2:0] btn;
  } tick_in_t;

  typedef struct packed {
    logic [2:0] pad;
    phase_t     phase;
    mode_t      mode;
    logic [7:0] green;
    logic [7:0] yellow;
    logic [7:0] red;
  } tick_out_t;

  typedef struct {
    logic [2:0] cmd;
    logic [9:0] pot;
    logic [2:0] btn;
    bit         typed;
    logic [7:0] r;
    logic [7:0] y;
    logic [7:0] g;
    mode_t      mode;
    phase_t     ph;
  } step_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  // button_one, button_two, button_three, pot_level[9:0], mode_command[2:0]
  logic [IN_BITS-1:0] in_tdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  // red_level[7:0], yellow_level[7:0], green_level[7:0], active_mode[1:0],
  // cycle_phase[2:0], zero padding
  logic [OUT_BITS-1:0] out_tdata;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [ADDR_BITS-1:0] cfg_paddr = '0;
  logic [DATA_BITS-1:0] cfg_pwdata = '0;
  logic [DATA_BITS-1:0] cfg_prdata;
  logic cfg_pready;

  traffic_light_mode_controller dut (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // predicted registers
  logic [15:0] red_ms, yellow_ms, green_ms, flicker_ms, blink_ms;
  logic [3:0] flick_toggles;
  logic [7:0] debounce_ms;

  // predicted state
  time_t clock_ms, phase_t0, blink_t0;
  time_t btn_accept [3];
  logic [2:0] btn_level;
  logic [3:0] flick_n;
  phase_t cyc_phase;
  pattern_t lamps;
  mode_t cur_mode;

  tick_out_t lamp_expect [$];
  int mismatches = 0;
  int sent_count = 0;
  int idle_mode = 0;
  logic rx_hold = 1'b0;
  logic [2:0] btn_drive = BTN_UP;

  step_row_t directed_rows [21] = '{
    '{CMD_NONE,    10'd1023, BTN_UP, 1'b1, 8'd255, 8'd0,   8'd0,   MODE_NORMAL, PH_RED},
    '{CMD_NONE,    10'd0,    BTN_UP, 1'b1, 8'd0,   8'd0,   8'd0,   MODE_NORMAL, PH_RED},
    '{CMD_HOLD,    10'd1023, BTN_UP, 1'b1, 8'd255, 8'd0,   8'd0,   MODE_HOLD,   PH_RED},
    '{CMD_BLINK,   10'd1023, BTN_UP, 1'b1, 8'd255, 8'd255, 8'd255, MODE_BLINK,  PH_RED},
    '{CMD_OFF,     10'd512,  BTN_UP, 1'b1, 8'd0,   8'd0,   8'd0,   MODE_OFF,    PH_RED},
    '{CMD_SPARE_5, 10'd1023, BTN_UP, 1'b1, 8'd0,   8'd0,   8'd0,   MODE_OFF,    PH_RED},
    '{CMD_SPARE_6, 10'd1023, BTN_UP, 1'b1, 8'd0,   8'd0,   8'd0,   MODE_OFF,    PH_RED},
    '{CMD_SPARE_7, 10'd1023, BTN_UP, 1'b1, 8'd0,   8'd0,   8'd0,   MODE_OFF,    PH_RED},
    '{CMD_RESTART, 10'd1023, BTN_UP, 1'b1, 8'd255, 8'd0,   8'd0,   MODE_NORMAL, PH_RED},
    // presses inside the debounce window after reset are ignored
    '{CMD_NONE,    10'd1023, 3'b110, 1'b1, 8'd255, 8'd0,   8'd0,   MODE_NORMAL, PH_RED},
    '{CMD_NONE,    10'd1023, 3'b101, 1'b1, 8'd255, 8'd0,   8'd0,   MODE_NORMAL, PH_RED},
    '{CMD_NONE,    10'd1023, 3'b011, 1'b1, 8'd255, 8'd0,   8'd0,   MODE_NORMAL, PH_RED},
    '{CMD_NONE,    10'd1023, 3'b000, 1'b1, 8'd255, 8'd0,   8'd0,   MODE_NORMAL, PH_RED},
    '{CMD_NONE,    10'd1,    BTN_UP, 1'b0, 8'd0,   8'd0,   8'd0,   MODE_NORMAL, PH_RED},
    '{CMD_NONE,    10'd5,    BTN_UP, 1'b0, 8'd0,   8'd0,   8'd0,   MODE_NORMAL, PH_RED},
    '{CMD_NONE,    10'h2AA,  3'b010, 1'b0, 8'd0,   8'd0,   8'd0,   MODE_NORMAL, PH_RED},
    '{CMD_NONE,    10'h155,  3'b101, 1'b0, 8'd0,   8'd0,   8'd0,   MODE_NORMAL, PH_RED},
    '{CMD_BLINK,   10'd777,  BTN_UP, 1'b0, 8'd0,   8'd0,   8'd0,   MODE_NORMAL, PH_RED},
    '{CMD_NONE,    10'd1000, BTN_UP, 1'b0, 8'd0,   8'd0,   8'd0,   MODE_NORMAL, PH_RED},
    '{CMD_HOLD,    10'd300,  BTN_UP, 1'b0, 8'd0,   8'd0,   8'd0,   MODE_NORMAL, PH_RED},
    '{CMD_RESTART, 10'd1022, BTN_UP, 1'b0, 8'd0,   8'd0,   8'd0,   MODE_NORMAL, PH_RED}
  };

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("tb NOT OK");
    $finish;
  end

  function automatic void restart_cycle(time_t now);
    cur_mode = MODE_NORMAL;
    phase_t0 = now;
    cyc_phase = PH_RED;
  endfunction

  function automatic void enter_mode(mode_t m);
    cur_mode = m;
    if (m == MODE_HOLD) lamps = PAT_RED;
    else if (m == MODE_BLINK) lamps = PAT_ALL;
    else lamps = PAT_OFF;
  endfunction

  function automatic tick_out_t predict_tick(tick_in_t w);
    time_t now;
    time_t el;
    logic [7:0] bright;
    tick_out_t o;
    now = clock_ms;
    bright = 8'((w.pot * 18'd255) / 18'd1023);
    for (int k = 0; k < 3; k++) begin
      if (w.btn[k] != btn_level[k] && (now - btn_accept[k]) >= time_t'(debounce_ms)) begin
        btn_accept[k] = now;
        if (btn_level[k] && !w.btn[k]) begin
          if (cur_mode != mode_t'(k + 1)) enter_mode(mode_t'(k + 1));
          else restart_cycle(now);
        end
        btn_level[k] = w.btn[k];
      end
    end
    case (w.cmd)
      CMD_RESTART: restart_cycle(now);
      CMD_HOLD: enter_mode(MODE_HOLD);
      CMD_BLINK: enter_mode(MODE_BLINK);
      CMD_OFF: enter_mode(MODE_OFF);
      default: ;
    endcase
    if (cur_mode == MODE_NORMAL) begin
      el = now - phase_t0;
      case (cyc_phase)
        PH_RED: begin
          lamps = PAT_RED;
          if (el >= red_ms) begin
            phase_t0 = now;
            cyc_phase = PH_YELLOW1;
          end
        end
        PH_YELLOW1: begin
          lamps = PAT_YELLOW;
          if (el >= yellow_ms) begin
            phase_t0 = now;
            cyc_phase = PH_GREEN;
          end
        end
        PH_GREEN: begin
          lamps = PAT_GREEN;
          if (el >= green_ms) begin
            phase_t0 = now;
            cyc_phase = PH_FLICKER;
            flick_n = '0;
          end
        end
        PH_FLICKER: begin
          if (el >= flicker_ms) begin
            phase_t0 = now;
            lamps = (lamps == PAT_GREEN) ? PAT_OFF : PAT_GREEN;
            flick_n = flick_n + 4'd1;
            if (flick_n >= flick_toggles) cyc_phase = PH_YELLOW2;
          end
        end
        PH_YELLOW2: begin
          lamps = PAT_YELLOW;
          if (el >= yellow_ms) begin
            phase_t0 = now;
            cyc_phase = PH_RED;
          end
        end
        default: begin
          phase_t0 = now;
          cyc_phase = PH_RED;
        end
      endcase
    end
    o = '0;
    if (cur_mode == MODE_BLINK) begin
      if ((now - blink_t0) >= blink_ms) begin
        blink_t0 = now;
        lamps = (lamps == PAT_ALL) ? PAT_OFF : PAT_ALL;
      end
      if (lamps == PAT_ALL) begin
        o.red = bright;
        o.yellow = bright;
        o.green = bright;
      end
    end else begin
      case (lamps)
        PAT_RED: o.red = bright;
        PAT_YELLOW: o.yellow = bright;
        PAT_GREEN: o.green = bright;
        default: ;
      endcase
    end
    o.mode = cur_mode;
    o.phase = cyc_phase;
    clock_ms = clock_ms + 1;
    return o;
  endfunction

  function automatic tick_in_t random_tick();
    tick_in_t w;
    for (int k = 0; k < 3; k++) begin
      if ($urandom_range(15) == 0) btn_drive[k] = ~btn_drive[k];
    end
    w.btn = btn_drive;
    w.cmd = ($urandom_range(23) == 0) ? 3'($urandom_range(1, 7)) : CMD_NONE;
    case ($urandom_range(7))
      0: w.pot = 10'd0;
      1: w.pot = 10'd1023;
      default: w.pot = 10'($urandom);
    endcase
    return w;
  endfunction

  function automatic bit sender_waits();
    int pct;
    pct = (idle_mode == 0) ? 8 : (idle_mode == 1) ? 78 : 0;
    return $urandom_range(99) < pct;
  endfunction

  task automatic send_word(input tick_in_t w);
    if (sender_waits()) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while (sender_waits()) @(posedge clk);
    end
    in_tdata <= w;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_count++;
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= ADDR_BITS'({idx, 2'b00});
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (idx)
      REG_RED_TIME: red_ms = value[15:0];
      REG_YELLOW_TIME: yellow_ms = value[15:0];
      REG_GREEN_TIME: green_ms = value[15:0];
      REG_FLICKER_TIME: flicker_ms = value[15:0];
      REG_FLICKER_TGL: flick_toggles = value[3:0];
      REG_DEBOUNCE: debounce_ms = value[7:0];
      REG_BLINK_TIME: blink_ms = value[15:0];
      default: ;
    endcase
  endtask

  task automatic load_setting(input int p);
    logic [15:0] v [7];
    int span;
    case (p)
      0: v = '{16'd5, 16'd3, 16'd4, 16'd2, 16'd3, 16'd2, 16'd3};
      1: v = '{16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd0, 16'd1};
      // zero times and zero toggles advance on every tick
      2: v = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
      3: v = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd15, 16'd255, 16'hFFFF};
      default: begin
        span = (p == 4) ? 12 : 40;
        for (int i = 0; i < 7; i++) v[i] = 16'($urandom_range(1, span));
        v[REG_FLICKER_TGL] = 16'($urandom_range(1, 15));
        v[REG_DEBOUNCE] = 16'($urandom_range(0, span / 2));
      end
    endcase
    for (int i = 0; i < 7; i++) write_reg(reg_idx_t'(i), {16'd0, v[i]});
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (lamp_expect.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // output side: stalls, long hold-off, and checking
  always @(posedge clk) begin
    tick_out_t got;
    tick_out_t want;
    int pct;
    pct = (idle_mode == 0) ? 78 : (idle_mode == 1) ? 8 : 0;
    out_tready <= !rx_hold && ($urandom_range(99) >= pct);
    if (rst_n && out_tvalid && out_tready) begin
      got = tick_out_t'(out_tdata);
      if (lamp_expect.size() == 0) begin
        $error("unexpected word %h", out_tdata);
        mismatches++;
      end else begin
        want = lamp_expect.pop_front();
        if (got.red !== want.red) begin
          $error("red_level expected %0d got %0d", want.red, got.red);
          mismatches++;
        end
        if (got.yellow !== want.yellow) begin
          $error("yellow_level expected %0d got %0d", want.yellow, got.yellow);
          mismatches++;
        end
        if (got.green !== want.green) begin
          $error("green_level expected %0d got %0d", want.green, got.green);
          mismatches++;
        end
        if (got.mode !== want.mode) begin
          $error("active_mode expected %0d got %0d", want.mode, got.mode);
          mismatches++;
        end
        if (got.phase !== want.phase) begin
          $error("cycle_phase expected %0d got %0d", want.phase, got.phase);
          mismatches++;
        end
        if (got.pad !== want.pad) begin
          $error("padding expected %0d got %0d", want.pad, got.pad);
          mismatches++;
        end
      end
    end
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    wait (sent_count >= HOLD_AT);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (100) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin
    tick_in_t w;
    tick_out_t pred;
    red_ms = RED_TIME_RST;
    yellow_ms = YELLOW_TIME_RST;
    green_ms = GREEN_TIME_RST;
    flicker_ms = FLICKER_TIME_RST;
    flick_toggles = FLICKER_TGL_RST;
    debounce_ms = DEBOUNCE_RST;
    blink_ms = BLINK_TIME_RST;
    clock_ms = '0;
    phase_t0 = '0;
    blink_t0 = '0;
    btn_accept = '{default: '0};
    btn_level = BTN_UP;
    flick_n = '0;
    cyc_phase = PH_RED;
    lamps = PAT_OFF;
    cur_mode = MODE_NORMAL;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      w.cmd = directed_rows[i].cmd;
      w.pot = directed_rows[i].pot;
      w.btn = directed_rows[i].btn;
      send_word(w);
      pred = predict_tick(w);
      if (directed_rows[i].typed)
        lamp_expect.push_back('{3'b000, directed_rows[i].ph, directed_rows[i].mode,
                                directed_rows[i].g, directed_rows[i].y, directed_rows[i].r});
      else
        lamp_expect.push_back(pred);
    end
    in_tvalid <= 1'b0;

    for (int p = 0; p < 6; p++) begin
      wait_drained();
      idle_mode <= p / 2;
      load_setting(p);
      btn_drive = btn_level;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        w = random_tick();
        send_word(w);
        lamp_expect.push_back(predict_tick(w));
      end
      in_tvalid <= 1'b0;
    end

    wait_drained();
    if (mismatches == 0 && lamp_expect.size() == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

endmodule
